// File: rtl/sle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types, codes and the set-1 scancode translation tables for the
// scancode line editor.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int LINE_CAPACITY_DEF = 128;

  typedef enum logic [1:0] {
    CMD_SCAN = 2'd0,
    CMD_READ = 2'd1,
    CMD_TAKE = 2'd2
  } command_t;

  localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
  localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;

  localparam logic [6:0] CH_NONE      = 7'd0;
  localparam logic [6:0] CH_BACKSPACE = 7'd8;
  localparam logic [6:0] CH_TAB       = 7'd9;
  localparam logic [6:0] CH_NEWLINE   = 7'd10;

  // Translate a make code; unmapped codes give CH_NONE.
  function automatic logic [6:0] sle_map(input logic shifted, input logic [6:0] code);
    logic [7:0] c;
    c = 8'h00;
    case (code)
      7'h02: c = shifted ? "!" : "1";
      7'h03: c = shifted ? "@" : "2";
      7'h04: c = shifted ? "#" : "3";
      7'h05: c = shifted ? "$" : "4";
      7'h06: c = shifted ? "%" : "5";
      7'h07: c = shifted ? "^" : "6";
      7'h08: c = shifted ? "&" : "7";
      7'h09: c = shifted ? "*" : "8";
      7'h0A: c = shifted ? "(" : "9";
      7'h0B: c = shifted ? ")" : "0";
      7'h0C: c = shifted ? "_" : "-";
      7'h0D: c = shifted ? "+" : "=";
      7'h0E: c = {1'b0, CH_BACKSPACE};
      7'h0F: c = shifted ? 8'h00 : {1'b0, CH_TAB};
      7'h10: c = shifted ? "Q" : "q";
      7'h11: c = shifted ? "W" : "w";
      7'h12: c = shifted ? "E" : "e";
      7'h13: c = shifted ? "R" : "r";
      7'h14: c = shifted ? "T" : "t";
      7'h15: c = shifted ? "Y" : "y";
      7'h16: c = shifted ? "U" : "u";
      7'h17: c = shifted ? "I" : "i";
      7'h18: c = shifted ? "O" : "o";
      7'h19: c = shifted ? "P" : "p";
      7'h1C: c = {1'b0, CH_NEWLINE};
      7'h1E: c = shifted ? "A" : "a";
      7'h1F: c = shifted ? "S" : "s";
      7'h20: c = shifted ? "D" : "d";
      7'h21: c = shifted ? "F" : "f";
      7'h22: c = shifted ? "G" : "g";
      7'h23: c = shifted ? "H" : "h";
      7'h24: c = shifted ? "J" : "j";
      7'h25: c = shifted ? "K" : "k";
      7'h26: c = shifted ? "L" : "l";
      7'h2C: c = shifted ? "Z" : "z";
      7'h2D: c = shifted ? "X" : "x";
      7'h2E: c = shifted ? "C" : "c";
      7'h2F: c = shifted ? "V" : "v";
      7'h30: c = shifted ? "B" : "b";
      7'h31: c = shifted ? "N" : "n";
      7'h32: c = shifted ? "M" : "m";
      7'h39: c = " ";
      default: c = 8'h00;
    endcase
    return c[6:0];
  endfunction

  // Result word fields other than the store read data.
  typedef struct packed {
    logic       echo_valid;
    logic [6:0] echo_char;
    logic       rd_en;
    logic [7:0] line_length;
    logic       line_done;
    logic       shift_active;
  } stage_t;

endpackage

// File: rtl/sle_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_if
// Valid/ready channels of the scancode line editor: command words in,
// result words out.
// ----------------------------------------------------------------------------
interface sle_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] scancode;
  logic [6:0] read_index;

  modport source (output valid, command, scancode, read_index, input ready);
  modport sink   (input valid, command, scancode, read_index, output ready);
endinterface

interface sle_res_if;
  logic       valid;
  logic       ready;
  logic       echo_valid;
  logic [6:0] echo_char;
  logic [6:0] read_char;
  logic [7:0] line_length;
  logic       line_done;
  logic       shift_active;

  modport source (output valid, echo_valid, echo_char, read_char, line_length,
                  line_done, shift_active, input ready);
  modport sink   (input valid, echo_valid, echo_char, read_char, line_length,
                  line_done, shift_active, output ready);
endinterface

// File: rtl/scancode_line_editor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scancode_line_editor
// Set-1 scancode to ASCII line editor with a character store.
// ----------------------------------------------------------------------------
// One command word per cycle is accepted while the read stage is empty or
// advancing, and each yields exactly one result word: the accept edge loads
// the store read stage, which then passes it on to the output register.
// Scancode words track shift, translate make codes and edit the line (append,
// backspace, newline sets line ready); read words fetch a stored character (0
// at or past the length); take words clear the length and the ready flag. The
// line lives in a LINE_CAPACITY x 7 one-write, one-read synchronous memory,
// written at the accept edge and read through a registered port; the scalar
// state (shift, length, ready) sits in flops so the next word sees it
// at once. No clearing pass is needed after reset. The output register lets a
// new word in while a result waits to be taken.
// ----------------------------------------------------------------------------
module scancode_line_editor
  import sle_pkg::*;
#(
  parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  sle_cmd_if.sink  in_if,
  sle_res_if.source out_if
);

  localparam int CW = $clog2(LINE_CAPACITY + 1);
  localparam int AW = $clog2(LINE_CAPACITY);

  // Line store.
  logic [6:0] mem [LINE_CAPACITY];
  logic [6:0] mem_q_r;

  // Scalar state.
  logic          shift_r, shift_nxt;
  logic          ready_r, ready_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // Pipeline: read stage and output register.
  logic   s1_v_r, out_v_r;
  stage_t s1_r, s1_nxt;
  stage_t out_r;
  logic [6:0] out_rd_r;

  logic accept, s1_adv;
  logic wr_en;
  logic [6:0] wr_data;
  logic [AW-1:0] wr_addr, rd_addr;
  logic rd_hit;
  logic [6:0] ch;
  logic [CW+6:0] idx_ext, cnt_ext;
  logic [CW+7:0] len_ext;

  // Advance the read stage when the output register is free or draining.
  assign s1_adv       = s1_v_r && (!out_v_r || out_if.ready);
  assign in_if.ready  = !s1_v_r || s1_adv;
  assign accept       = in_if.valid && in_if.ready;

  assign idx_ext = {{CW{1'b0}}, in_if.read_index};
  assign cnt_ext = {7'b0, count_r};
  assign rd_hit  = idx_ext < cnt_ext;
  assign rd_addr = idx_ext[AW-1:0];
  assign wr_addr = count_r[AW-1:0];

  // Command decode and state update.
  always_comb begin
    shift_nxt = shift_r;
    ready_nxt = ready_r;
    count_nxt = count_r;
    wr_en     = 1'b0;
    wr_data   = CH_NONE;
    ch        = CH_NONE;
    s1_nxt    = '0;
    unique case (command_t'(in_if.command))
      CMD_SCAN: begin
        if (in_if.scancode == SC_LSHIFT_MAKE || in_if.scancode == SC_RSHIFT_MAKE) begin
          shift_nxt = 1'b1;
        end else if (in_if.scancode == SC_LSHIFT_BREAK ||
                     in_if.scancode == SC_RSHIFT_BREAK) begin
          shift_nxt = 1'b0;
        end
        // Break codes carry bit 7 and translate to nothing.
        if (!in_if.scancode[7]) begin
          ch = sle_map(shift_nxt, in_if.scancode[6:0]);
        end
        if (ch == CH_NEWLINE) begin
          ready_nxt         = 1'b1;
          s1_nxt.echo_valid = 1'b1;
          s1_nxt.echo_char  = CH_NEWLINE;
        end else if (ch == CH_BACKSPACE) begin
          if (count_r != '0) begin
            count_nxt         = count_r - CW'(1);
            s1_nxt.echo_valid = 1'b1;
            s1_nxt.echo_char  = CH_BACKSPACE;
          end
        end else if (ch != CH_NONE && count_r < CW'(LINE_CAPACITY)) begin
          wr_en             = 1'b1;
          wr_data           = ch;
          count_nxt         = count_r + CW'(1);
          s1_nxt.echo_valid = 1'b1;
          s1_nxt.echo_char  = ch;
        end
      end
      CMD_READ: begin
        s1_nxt.rd_en = rd_hit;
      end
      CMD_TAKE: begin
        ready_nxt = 1'b0;
        count_nxt = '0;
      end
      default: begin
      end
    endcase
    len_ext             = {8'b0, count_nxt};
    s1_nxt.line_length  = len_ext[7:0];
    s1_nxt.line_done    = ready_nxt;
    s1_nxt.shift_active = shift_nxt;
  end

  // Store write and registered read; hold read data while the stage stalls.
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (accept) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= 1'b0;
      ready_r <= 1'b0;
      count_r <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (accept) begin
        shift_r <= shift_nxt;
        ready_r <= ready_nxt;
        count_r <= count_nxt;
      end
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (out_if.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
    if (s1_adv) begin
      out_r    <= s1_r;
      out_rd_r <= s1_r.rd_en ? mem_q_r : CH_NONE;
    end
  end

  assign out_if.valid        = out_v_r;
  assign out_if.echo_valid   = out_r.echo_valid;
  assign out_if.echo_char    = out_r.echo_char;
  assign out_if.read_char    = out_rd_r;
  assign out_if.line_length  = out_r.line_length;
  assign out_if.line_done    = out_r.line_done;
  assign out_if.shift_active = out_r.shift_active;

  // Length never passes the store capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(LINE_CAPACITY))
    else $error("line length exceeds capacity");

  // A take word leaves an empty, not-ready line.
  a_take_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_if.command == CMD_TAKE |=> count_r == '0 && !ready_r)
    else $error("take did not clear the line");

  // An echo always carries a real character.
  a_echo_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.echo_valid |-> out_r.echo_char != CH_NONE)
    else $error("echo with null character");

  // A read that hits the store targets an entry below the length.
  a_read_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_if.command == CMD_READ && rd_hit |-> {1'b0, rd_addr} < {1'b0, count_r})
    else $error("store read beyond length");

endmodule
